### rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

    typedef enum logic [2:0] {
        KIND_LOAD     = 3'd0,
        KIND_MUL_INT  = 3'd1,
        KIND_MUL_FRAC = 3'd2,
        KIND_ADD      = 3'd3,
        KIND_SUB      = 3'd4,
        KIND_RECIP    = 3'd5,
        KIND_REDUCE   = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_GCD_TWOS,
        ST_GCD_XODD,
        ST_GCD_LOOP,
        ST_GCD_SCALE,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               keep_state;
        logic signed [31:0] operand_numerator;
        logic signed [31:0] operand_denominator;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic signed [31:0] result_denominator;
        logic               zero_denominator;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/rational_arithmetic_unit.sv
`default_nettype none

// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------
// cmd      | in        | cmd_valid / cmd_ready    | cmd_t: kind, keep_state, operand
// rsp      | out       | rsp_valid / rsp_ready    | rsp_t: result fraction, zero flag
//
// one command at a time; cmd_ready is high only while the sequencer is idle.
// load, reciprocal and unused kinds go straight to the final step. products use a
// shift-add multiplier (1, 2 or 3 products), early out on zero. reduce: binary gcd,
// then two restoring divisions.
// reset gives 0/1 with no result pending; a stalled rsp only holds the final step.

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = 32
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic cmd_valid,
    output       logic cmd_ready,
    input  wire  cmd_t cmd,
    output       logic rsp_valid,
    input  wire  logic rsp_ready,
    output       rsp_t rsp
);

    localparam int W     = WORD_WIDTH;
    localparam int CNT_W = $clog2(WORD_WIDTH);

    typedef logic [W-1:0] word_t;

    state_t              state_reg, state_next;
    word_t               acc_num_reg, acc_num_next;
    word_t               acc_den_reg, acc_den_next;
    word_t               res_num_reg, res_num_next;
    word_t               res_den_reg, res_den_next;
    logic [2:0]          kind_reg, kind_next;
    logic                keep_reg, keep_next;
    word_t               c_reg, c_next;
    word_t               d_reg, d_next;
    logic [1:0]          mul_idx_reg, mul_idx_next;
    word_t               mcand_reg, mcand_next;
    word_t               mplier_reg, mplier_next;
    word_t               prod_reg, prod_next;
    word_t               x_reg, x_next;
    word_t               y_reg, y_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    word_t               rem_reg, rem_next;
    word_t               quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // width conversion of the 32-bit fields
    logic signed [63:0]  c_ext, d_ext, num_ext, den_ext;
    word_t               c_in, d_in;

    // operand selection for the multiplier
    logic [2:0]          sel_kind;
    logic [1:0]          sel_idx;
    word_t               sel_c, sel_d, sel_mcand, sel_mplier;
    logic                mul_last;
    word_t               prod_sum;

    // reduction helpers
    logic                a_neg, b_neg;
    word_t               a_mag, b_mag;
    word_t               x_minus_y, y_minus_x;
    logic [W:0]          div_shift, div_trial;
    word_t               quo_final, quo_signed;
    logic                div_last;

    assign c_ext = 64'(cmd.operand_numerator);
    assign d_ext = 64'(cmd.operand_denominator);
    assign c_in  = c_ext[W-1:0];
    assign d_in  = d_ext[W-1:0];

    assign num_ext = 64'(signed'(res_num_reg));
    assign den_ext = 64'(signed'(res_den_reg));

    assign a_neg = acc_num_reg[W-1];
    assign b_neg = acc_den_reg[W-1];
    assign a_mag = a_neg ? (word_t'(0) - acc_num_reg) : acc_num_reg;
    assign b_mag = b_neg ? (word_t'(0) - acc_den_reg) : acc_den_reg;

    assign x_minus_y = x_reg - y_reg;
    assign y_minus_x = y_reg - x_reg;

    assign div_shift = {rem_reg, quo_reg[W-1]};
    assign div_trial = div_shift - {1'b0, x_reg};
    assign quo_final = {quo_reg[W-2:0], ~div_trial[W]};
    assign div_last  = (cnt_reg == CNT_W'(W - 1));

    assign prod_sum = prod_reg + (mplier_reg[0] ? mcand_reg : word_t'(0));

    // operands of the next product: the first one at accept, later ones from stored kind
    always_comb
    begin
        sel_kind = (state_reg == ST_IDLE) ? cmd.kind : kind_reg;
        sel_idx  = (state_reg == ST_IDLE) ? 2'd0 : mul_idx_reg + 2'd1;
        sel_c    = (state_reg == ST_IDLE) ? c_in : c_reg;
        sel_d    = (state_reg == ST_IDLE) ? d_in : d_reg;
        sel_mcand = (sel_idx == 2'd0) ? acc_num_reg : acc_den_reg;
        priority if (sel_kind == KIND_MUL_INT || sel_kind == KIND_MUL_FRAC)
        begin
            sel_mplier = (sel_idx == 2'd0) ? sel_c : sel_d;
        end
        else
        begin
            sel_mplier = (sel_idx == 2'd1) ? sel_c : sel_d;
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            KIND_MUL_INT:  mul_last = (mul_idx_reg == 2'd0);
            KIND_MUL_FRAC: mul_last = (mul_idx_reg == 2'd1);
            default:       mul_last = (mul_idx_reg == 2'd2);
        endcase
    end

    assign quo_signed = (state_reg == ST_DIV_NUM)
                      ? (a_neg ? (word_t'(0) - quo_final) : quo_final)
                      : (b_neg ? (word_t'(0) - quo_final) : quo_final);

    always_comb
    begin
        state_next     = state_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        kind_next      = kind_reg;
        keep_next      = keep_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        mul_idx_next   = mul_idx_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next    = cmd.kind;
                    keep_next    = cmd.keep_state;
                    c_next       = c_in;
                    d_next       = d_in;
                    res_num_next = acc_num_reg;
                    res_den_next = acc_den_reg;
                    mul_idx_next = 2'd0;
                    mcand_next   = sel_mcand;
                    mplier_next  = sel_mplier;
                    prod_next    = '0;
                    x_next       = a_mag;
                    y_next       = b_mag;
                    k_next       = '0;
                    rem_next     = '0;
                    quo_next     = a_mag;
                    cnt_next     = '0;
                    state_next   = ST_DONE;
                    unique case (cmd.kind)
                        KIND_LOAD:
                        begin
                            res_num_next = c_in;
                            res_den_next = d_in;
                        end
                        KIND_MUL_INT, KIND_MUL_FRAC, KIND_ADD, KIND_SUB:
                        begin
                            state_next = ST_MUL;
                        end
                        KIND_RECIP:
                        begin
                            res_num_next = acc_den_reg;
                            res_den_next = acc_num_reg;
                        end
                        KIND_REDUCE:
                        begin
                            priority if (acc_num_reg == '0 && acc_den_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (acc_num_reg == '0)
                            begin
                                res_den_next = word_t'(1);
                            end
                            else if (acc_den_reg == '0)
                            begin
                                // gcd is the numerator magnitude itself
                                state_next = ST_DIV_NUM;
                            end
                            else
                            begin
                                state_next = ST_GCD_TWOS;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    unique case (mul_idx_reg)
                        2'd0:    res_num_next = prod_reg;
                        2'd1:
                        begin
                            if (kind_reg == KIND_ADD)
                            begin
                                res_num_next = res_num_reg + prod_reg;
                            end
                            else if (kind_reg == KIND_SUB)
                            begin
                                res_num_next = res_num_reg - prod_reg;
                            end
                            else
                            begin
                                res_den_next = prod_reg;
                            end
                        end
                        default: res_den_next = prod_reg;
                    endcase
                    if (mul_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mul_idx_next = mul_idx_reg + 2'd1;
                        mcand_next   = sel_mcand;
                        mplier_next  = sel_mplier;
                        prod_next    = '0;
                    end
                end
                else
                begin
                    prod_next   = prod_sum;
                    mcand_next  = {mcand_reg[W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[W-1:1]};
                end
            end

            ST_GCD_TWOS:
            begin
                if (x_reg[0] == 1'b0 && y_reg[0] == 1'b0)
                begin
                    x_next = {1'b0, x_reg[W-1:1]};
                    y_next = {1'b0, y_reg[W-1:1]};
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_GCD_XODD;
                end
            end

            ST_GCD_XODD:
            begin
                if (x_reg[0] == 1'b0)
                begin
                    x_next = {1'b0, x_reg[W-1:1]};
                end
                else
                begin
                    state_next = ST_GCD_LOOP;
                end
            end

            ST_GCD_LOOP:
            begin
                priority if (y_reg == '0)
                begin
                    state_next = ST_GCD_SCALE;
                end
                else if (y_reg[0] == 1'b0)
                begin
                    y_next = {1'b0, y_reg[W-1:1]};
                end
                else if (x_reg > y_reg)
                begin
                    x_next = y_reg;
                    y_next = x_minus_y;
                end
                else
                begin
                    y_next = y_minus_x;
                end
            end

            ST_GCD_SCALE:
            begin
                // restore the common power of two
                if (k_reg == '0)
                begin
                    state_next = ST_DIV_NUM;
                end
                else
                begin
                    x_next = {x_reg[W-2:0], 1'b0};
                    k_next = k_reg - CNT_W'(1);
                end
            end

            ST_DIV_NUM, ST_DIV_DEN:
            begin
                // restoring division, divisor held in x
                quo_next = quo_final;
                rem_next = div_trial[W] ? div_shift[W-1:0] : div_trial[W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == ST_DIV_NUM)
                    begin
                        res_num_next = quo_signed;
                        quo_next     = b_mag;
                        state_next   = ST_DIV_DEN;
                    end
                    else
                    begin
                        res_den_next = quo_signed;
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.result_numerator   = num_ext[31:0];
                    rsp_next.result_denominator = den_ext[31:0];
                    rsp_next.zero_denominator   = (res_den_reg == '0);
                    rsp_valid_next              = 1'b1;
                    if (!keep_reg)
                    begin
                        acc_num_next = res_num_reg;
                        acc_den_next = res_den_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_num_reg   <= '0;
            acc_den_reg   <= word_t'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        kind_reg    <= kind_next;
        keep_reg    <= keep_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        mul_idx_reg <= mul_idx_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        prod_reg    <= prod_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        rsp_reg     <= rsp_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
